/* rtl/dmw_pkg.sv */
// dmw_pkg: shared widths, codes and the controller command bundle for the
// displacement map warp. No dependencies.
package dmw_pkg;

  localparam int PIXEL_W   = 32;  // RGBA, 8 bits per channel
  localparam int DISP_W    = 24;  // signed fixed point displacement
  localparam int DIM_REG_W = 9;   // frame size register width
  localparam int CFG_IDX_W = 2;   // register index width

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DISP = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;   // write source pixel, advance load position
    logic capture;   // register coordinate sums, advance output position
    logic mag_en;    // magnitude / truncation stage
    logic refl_en;   // mirror and clamp stage
    logic addr_en;   // raster address stage
    logic rd_en;     // frame store read
    logic out_load;  // load result register
  } dmw_cmd_t;

endpackage

/* rtl/dmw_if.sv */
// dmw_if: handshake channel interfaces (item in, result out, config write).
// Depends on dmw_pkg.
interface dmw_item_if import dmw_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [PIXEL_W-1:0]       src_pixel;
  logic signed [DISP_W-1:0] disp_x;
  logic signed [DISP_W-1:0] disp_y;

  modport source (output valid, func, src_pixel, disp_x, disp_y, input ready);
  modport sink   (input valid, func, src_pixel, disp_x, disp_y, output ready);
endinterface

interface dmw_res_if import dmw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               frame_end;

  modport source (output valid, out_pixel, frame_end, input ready);
  modport sink   (input valid, out_pixel, frame_end, output ready);
endinterface

interface dmw_cfg_if import dmw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dmw_ram.sv */
// dmw_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module dmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dmw_ctrl.sv */
// dmw_ctrl: sequencer for load and displace items, owns result valid.
// Depends on dmw_pkg.
module dmw_ctrl import dmw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_func,
  output logic     item_ready,
  input  logic     res_ready,
  output logic     res_valid,
  output dmw_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAG  = 3'd1;
  localparam logic [2:0] ST_REFL = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_func == FUNC_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_MAG;
          end
        end
      end
      ST_MAG: begin
        cmd.mag_en = 1'b1;
        state_next = ST_REFL;
      end
      ST_REFL: begin
        cmd.refl_en = 1'b1;
        state_next  = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_next  = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait until the result register is free
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/dmw_dp.sv */
// dmw_dp: frame size registers, position counters, coordinate warp stages,
// frame store and result register. Depends on dmw_pkg and dmw_ram.
module dmw_dp import dmw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dmw_cmd_t                 cmd,
  input  logic [PIXEL_W-1:0]       src_pixel,
  input  logic signed [DISP_W-1:0] disp_x,
  input  logic signed [DISP_W-1:0] disp_y,
  input  logic                     cfg_wr,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_REG_W-1:0]     cfg_data,
  output logic [PIXEL_W-1:0]       out_pixel,
  output logic                     frame_end
);

  localparam int XW    = $clog2(MAX_WIDTH);        // column index
  localparam int YW    = $clog2(MAX_HEIGHT);       // row index
  localparam int XDW   = $clog2(MAX_WIDTH + 1);    // effective width
  localparam int YDW   = $clog2(MAX_HEIGHT + 1);   // effective height
  localparam int CMAX  = (XW > YW) ? XW : YW;
  localparam int SW    = ((CMAX + FRAC_BITS > DISP_W) ? CMAX + FRAC_BITS : DISP_W) + 2;
  localparam int MW    = SW - FRAC_BITS;           // integer magnitude
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = XDW + YDW;                // pixel count
  localparam int PW    = YW + XDW;                 // row * width product
  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  // |sum| truncated: truncation toward zero followed by the low-edge mirror
  function automatic logic [MW-1:0] mag_of(input logic [SW-1:0] s);
    logic [SW-1:0] a;
    a = s[SW-1] ? (~s + 1'b1) : s;
    return a[SW-1:FRAC_BITS];
  endfunction

  // high-edge mirror, then clamp at zero
  function automatic logic [MW-1:0] reflect(input logic [MW-1:0] mag,
                                            input logic [MW-1:0] maxv);
    logic [MW-1:0] twice;
    twice = maxv << 1;
    if (mag <= maxv) return mag;
    else if (mag <= twice) return twice - mag;
    else return '0;
  endfunction

  logic [XDW-1:0] w_eff;
  logic [YDW-1:0] h_eff;
  logic [XDW-1:0] w_wr;
  logic [YDW-1:0] h_wr;
  logic [AW-1:0]  load_pos;
  logic [XW-1:0]  out_col;
  logic [YW-1:0]  out_row;
  logic [TW-1:0]  total;
  logic           ld_wrap;
  logic           col_wrap;
  logic           row_wrap;
  logic           cfg_hit;

  logic [SW-1:0]  sum_x;
  logic [SW-1:0]  sum_y;
  logic [MW-1:0]  mag_x;
  logic [MW-1:0]  mag_y;
  logic [XW-1:0]  nx;
  logic [YW-1:0]  ny;
  logic [AW-1:0]  rd_addr;
  logic [PW-1:0]  prod;
  logic           last;
  logic [PIXEL_W-1:0] rd_data;

  // clamp of written sizes
  always_comb begin
    if (cfg_data == '0) w_wr = XDW'(1);
    else if (int'(cfg_data) > MAX_WIDTH) w_wr = XDW'(MAX_WIDTH);
    else w_wr = XDW'(cfg_data);
    if (cfg_data == '0) h_wr = YDW'(1);
    else if (int'(cfg_data) > MAX_HEIGHT) h_wr = YDW'(MAX_HEIGHT);
    else h_wr = YDW'(cfg_data);
  end

  assign cfg_hit  = cfg_wr && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});
  assign total    = TW'(w_eff) * TW'(h_eff);
  assign ld_wrap  = (TW'(load_pos) + 1'b1 == total);
  assign col_wrap = (XDW'(out_col) + 1'b1 == w_eff);
  assign row_wrap = (YDW'(out_row) + 1'b1 == h_eff);
  assign prod     = PW'(ny) * PW'(w_eff);

  // sizes and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= XDW'(W_RST);
      h_eff    <= YDW'(H_RST);
      load_pos <= '0;
      out_col  <= '0;
      out_row  <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        w_eff <= w_wr;
      end else begin
        h_eff <= h_wr;
      end
      load_pos <= '0;
      out_col  <= '0;
      out_row  <= '0;
    end else begin
      if (cmd.load_wr) begin
        load_pos <= ld_wrap ? '0 : load_pos + 1'b1;
      end
      if (cmd.capture) begin
        if (col_wrap) begin
          out_col <= '0;
          out_row <= row_wrap ? '0 : out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // warp pipeline, one stage enabled at a time
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_x <= (SW'(out_col) << FRAC_BITS) + {{(SW-DISP_W){disp_x[DISP_W-1]}}, disp_x};
      sum_y <= (SW'(out_row) << FRAC_BITS) + {{(SW-DISP_W){disp_y[DISP_W-1]}}, disp_y};
      last  <= col_wrap && row_wrap;
    end
    if (cmd.mag_en) begin
      mag_x <= mag_of(sum_x);
      mag_y <= mag_of(sum_y);
    end
    if (cmd.refl_en) begin
      nx <= XW'(reflect(mag_x, MW'(w_eff) - 1'b1));
      ny <= YW'(reflect(mag_y, MW'(h_eff) - 1'b1));
    end
    if (cmd.addr_en) begin
      rd_addr <= AW'(prod + PW'(nx));
    end
    if (cmd.out_load) begin
      out_pixel <= rd_data;
      frame_end <= last;
    end
  end

  dmw_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load_wr),
    .waddr(load_pos),
    .wdata(src_pixel),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

endmodule

/* rtl/displacement_map_warp.sv */
// displacement_map_warp: per-pixel displacement warp with mirrored borders.
// Load items: one per cycle while the sequencer is idle, written straight into
// the frame store. Displace items: the sequencer walks sum, magnitude, mirror,
// address and store-read steps, then loads the result register; no new item
// is taken until that load. Result register frees the input side.
// Reset (rst, synchronous): sizes 256x256 (capped at MAX_*), positions zero.
module displacement_map_warp import dmw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input logic       clk,
  input logic       rst,
  dmw_item_if.sink  item,
  dmw_res_if.source result,
  dmw_cfg_if.sink   cfg
);

  dmw_cmd_t cmd;

  // config writes are always taken; sizes and positions update next cycle
  assign cfg.ready = 1'b1;

  // sequencer: loads pass in IDLE, displace items step through the warp
  dmw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_func (item.func),
    .item_ready(item.ready),
    .res_ready (result.ready),
    .res_valid (result.valid),
    .cmd       (cmd)
  );

  // datapath: counters, coordinate math, frame store, result register
  dmw_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .src_pixel(item.src_pixel),
    .disp_x   (item.disp_x),
    .disp_y   (item.disp_y),
    .cfg_wr   (cfg.valid),
    .cfg_index(cfg.index),
    .cfg_data (cfg.data),
    .out_pixel(result.out_pixel),
    .frame_end(result.frame_end)
  );

endmodule
